>>> hdl/utf8d_pkg.sv
// Package with the shared request and result types and status codes of the UTF-8 decoder.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodePointW = 21;
  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
  localparam logic [StatusW-1:0] STATUS_ILLEGAL = 2'd1;
  localparam logic [StatusW-1:0] STATUS_INCOMPLETE = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_stream;
  } request_t;

  typedef struct packed {
    logic [CodePointW-1:0] char_value;
    logic [StatusW-1:0]    status;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/utf8d_in_reg.sv
// Input register stage that holds one accepted request until the decoder core takes it.
`default_nettype none
module utf8d_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire utf8d_pkg::request_t item,
  output logic                   stage_valid,
  input  wire logic              stage_take,
  output utf8d_pkg::request_t    stage_item
);

  assign item_ready = !stage_valid || stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8d_core.sv
// Decoder core: sequence state, strict well-formedness check and the result register.
`default_nettype none
module utf8d_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                stage_valid,
  output logic                     stage_take,
  input  wire utf8d_pkg::request_t stage_item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output utf8d_pkg::result_t       result
);

  logic [2:0] seq_len;
  logic [2:0] seq_len_next;
  logic [1:0] count;
  logic [1:0] count_next;
  logic [7:0] held [3];
  logic       held_we;
  logic       emit;
  logic       seq_ok;
  logic [utf8d_pkg::CodePointW-1:0] seq_val;
  utf8d_pkg::result_t res_next;
  logic [7:0] b;
  logic       advance;

  assign advance = !result_valid || result_ready;
  assign stage_take = stage_valid && advance;
  assign b = stage_item.data_byte;

  function automatic logic is_cont(input logic [7:0] v);
    return v[7:6] == 2'b10;
  endfunction

  // Strict table check of a complete sequence, last byte taken straight from the stage.
  always_comb begin
    seq_ok = 1'b0;
    seq_val = '0;
    case (seq_len)
      3'd2: begin
        seq_ok = held[0] >= 8'hC2 && held[0] <= 8'hDF && is_cont(b);
        seq_val = {10'd0, held[0][4:0], b[5:0]};
      end
      3'd3: begin
        if (held[0] == 8'hE0) begin
          seq_ok = held[1] >= 8'hA0 && held[1] <= 8'hBF;
        end else if (held[0] == 8'hED) begin
          seq_ok = held[1] >= 8'h80 && held[1] <= 8'h9F;
        end else begin
          seq_ok = is_cont(held[1]);
        end
        seq_ok = seq_ok && is_cont(b);
        seq_val = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
      end
      default: begin
        if (held[0] == 8'hF0) begin
          seq_ok = held[1] >= 8'h90 && held[1] <= 8'hBF;
        end else if (held[0] >= 8'hF1 && held[0] <= 8'hF3) begin
          seq_ok = is_cont(held[1]);
        end else if (held[0] == 8'hF4) begin
          seq_ok = held[1] >= 8'h80 && held[1] <= 8'h8F;
        end else begin
          seq_ok = 1'b0;
        end
        seq_ok = seq_ok && is_cont(held[2]) && is_cont(b);
        seq_val = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
      end
    endcase
  end

  always_comb begin
    seq_len_next = seq_len;
    count_next = count;
    held_we = 1'b0;
    emit = 1'b0;
    res_next.char_value = '0;
    res_next.status = utf8d_pkg::STATUS_OK;
    if (seq_len == 3'd0) begin
      if (b < 8'h80) begin
        emit = 1'b1;
        res_next.char_value = {13'd0, b};
      end else if (b < 8'hC0) begin
        emit = 1'b1;
        res_next.status = utf8d_pkg::STATUS_ILLEGAL;
      end else begin
        held_we = 1'b1;
        count_next = 2'd1;
        seq_len_next = (b >= 8'hF0) ? 3'd4 : (b >= 8'hE0) ? 3'd3 : 3'd2;
        if (stage_item.end_of_stream) begin
          emit = 1'b1;
          res_next.status = utf8d_pkg::STATUS_INCOMPLETE;
        end
      end
    end else if ({1'b0, count} + 3'd1 >= seq_len) begin
      emit = 1'b1;
      if (seq_ok) begin
        res_next.char_value = seq_val;
      end else begin
        res_next.status = utf8d_pkg::STATUS_ILLEGAL;
      end
    end else begin
      held_we = 1'b1;
      count_next = count + 2'd1;
      if (stage_item.end_of_stream) begin
        emit = 1'b1;
        res_next.status = utf8d_pkg::STATUS_INCOMPLETE;
      end
    end
    // Any result sends the sequence state back to idle.
    if (emit) begin
      seq_len_next = 3'd0;
      count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= 3'd0;
      count <= 2'd0;
    end else if (stage_take) begin
      seq_len <= seq_len_next;
      count <= count_next;
    end
  end

  // The held count is the slot for the incoming byte while a sequence is being gathered.
  always_ff @(posedge clk) begin
    if (stage_take && held_we) begin
      held[count] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && emit) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8_validating_decoder.sv
// Top level of the strict UTF-8 decoder: input register stage feeding the decoder core.
// A request held in the input stage has its result, if any, registered when the core takes it.
// Throughput: one byte per cycle unless results stall; result and input stage advance together.
// A stalled result holds the pipeline, and the input stage takes a new byte as the core drains it.
// Reset (rst, synchronous, active high) empties both stages and returns the decoder to idle.
`default_nettype none
module utf8_validating_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire utf8d_pkg::request_t item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output utf8d_pkg::result_t       result
);

  logic                stage_valid;
  logic                stage_take;
  utf8d_pkg::request_t stage_item;

  utf8d_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .stage_valid (stage_valid),
    .stage_take  (stage_take),
    .stage_item  (stage_item)
  );

  utf8d_core u_core (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_take   (stage_take),
    .stage_item   (stage_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

>>> hdl/utf8d_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`default_nettype none
module utf8d_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire utf8d_pkg::result_t  result
);

  // A stalled result keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == utf8d_pkg::STATUS_OK ||
                      result.status == utf8d_pkg::STATUS_ILLEGAL ||
                      result.status == utf8d_pkg::STATUS_INCOMPLETE))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != utf8d_pkg::STATUS_OK |-> result.char_value == '0)
    else $error("code point not zero on an error status");

  // A decoded value is a scalar value: in range and not a surrogate.
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == utf8d_pkg::STATUS_OK |->
      result.char_value <= 21'h10FFFF &&
      !(result.char_value >= 21'h00D800 && result.char_value <= 21'h00DFFF))
    else $error("decoded value is not a scalar value");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result shown right after reset");

endmodule

bind utf8_validating_decoder utf8d_checker u_checker (.*);
`default_nettype wire

>>> bench/utf8_decode_checker.sv
// Checker for the UTF-8 decoder: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps
module utf8_decode_checker
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_ready,
  input  request_t item,
  input  logic     result_valid,
  input  logic     result_ready,
  input  result_t  result,
  output int       fail_count,
  output int       outstanding,
  output int       request_count,
  output int       char_count,
  output int       illegal_count,
  output int       incomplete_count
);

  // Decoder state as the block should hold it.
  logic [7:0] held [3];
  logic [2:0] seq_len;
  logic [1:0] collected;

  result_t pending_results [$];

  function automatic bit is_cont(logic [7:0] v);
    return v >= 8'h80 && v <= 8'hBF;
  endfunction

  function automatic bit well_formed(logic [3:0][7:0] s, int n);
    if (n == 2) return s[0] >= 8'hC2 && s[0] <= 8'hDF && is_cont(s[1]);
    if (n == 3) begin
      if (!is_cont(s[2])) return 1'b0;
      if (s[0] == 8'hE0) return s[1] >= 8'hA0 && s[1] <= 8'hBF;
      if (s[0] == 8'hED) return s[1] >= 8'h80 && s[1] <= 8'h9F;
      return is_cont(s[1]);
    end
    if (!is_cont(s[2]) || !is_cont(s[3])) return 1'b0;
    if (s[0] == 8'hF0) return s[1] >= 8'h90 && s[1] <= 8'hBF;
    if (s[0] >= 8'hF1 && s[0] <= 8'hF3) return is_cont(s[1]);
    if (s[0] == 8'hF4) return s[1] >= 8'h80 && s[1] <= 8'h8F;
    return 1'b0;
  endfunction

  function automatic logic [20:0] scalar_value(logic [3:0][7:0] s, int n);
    if (n == 2) return {10'd0, s[0][4:0], s[1][5:0]};
    if (n == 3) return {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
    return {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
  endfunction

  task automatic queue_result(logic [20:0] cp, logic [StatusW-1:0] st);
    result_t r;
    r.char_value = cp;
    r.status = st;
    pending_results.push_back(r);
    if (st == STATUS_OK) char_count++;
    else if (st == STATUS_ILLEGAL) illegal_count++;
    else incomplete_count++;
    seq_len = 3'd0;
    collected = 2'd0;
  endtask

  task automatic predict_decode(request_t req);
    logic [3:0][7:0] s;
    int n;
    if (seq_len == 3'd0) begin
      if (req.data_byte < 8'h80) begin
        queue_result({13'd0, req.data_byte}, STATUS_OK);
      end else if (req.data_byte < 8'hC0) begin
        queue_result('0, STATUS_ILLEGAL);
      end else begin
        held[0] = req.data_byte;
        collected = 2'd1;
        seq_len = (req.data_byte >= 8'hF0) ? 3'd4 : (req.data_byte >= 8'hE0) ? 3'd3 : 3'd2;
        if (req.end_of_stream) queue_result('0, STATUS_INCOMPLETE);
      end
    end else if (int'(collected) + 1 >= int'(seq_len)) begin
      // The whole sequence is in hand, so it is judged now, whatever end_of_stream says.
      n = int'(seq_len);
      s = '0;
      for (int k = 0; k < n - 1; k++) s[k] = held[k];
      s[n-1] = req.data_byte;
      if (well_formed(s, n)) queue_result(scalar_value(s, n), STATUS_OK);
      else queue_result('0, STATUS_ILLEGAL);
    end else begin
      held[collected] = req.data_byte;
      collected = collected + 2'd1;
      if (req.end_of_stream) queue_result('0, STATUS_INCOMPLETE);
    end
  endtask

  task automatic compare_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: char_value %h, status %0d", got.char_value, got.status);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.char_value !== want.char_value) begin
      $error("char_value mismatch: expected %h, got %h", want.char_value, got.char_value);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) held[k] = 8'd0;
      seq_len = 3'd0;
      collected = 2'd0;
      pending_results.delete();
      fail_count = 0;
      request_count = 0;
      char_count = 0;
      illegal_count = 0;
      incomplete_count = 0;
    end else begin
      if (item_valid && item_ready) begin
        predict_decode(item);
        request_count++;
      end
      if (result_valid && result_ready) compare_result(result);
    end
    outstanding = pending_results.size();
  end

endmodule

>>> bench/tb_utf8_validating_decoder.sv
// Testbench top for the UTF-8 decoder: byte stream stimulus, result stalls and the verdict.
`timescale 1ns / 100ps
module tb_utf8_validating_decoder;
  import utf8d_pkg::*;

  localparam int RandomBytes = 1000;
  localparam int CycleLimit = 200000;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_ready;
  request_t item;
  logic     result_valid;
  logic     result_ready;
  result_t  result;

  int fail_count;
  int outstanding;
  int request_count;
  int char_count;
  int illegal_count;
  int incomplete_count;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;

  request_t byte_stream [$];

  utf8_validating_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  utf8_decode_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .request_count    (request_count),
    .char_count       (char_count),
    .illegal_count    (illegal_count),
    .incomplete_count (incomplete_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic add_byte(logic [7:0] b, bit eos);
    request_t r;
    r.data_byte = b;
    r.end_of_stream = eos;
    byte_stream.push_back(r);
  endtask

  // A random well-formed sequence of n bytes; the second byte respects the lead's narrow range.
  function automatic logic [3:0][7:0] legal_sequence(int n);
    logic [3:0][7:0] s;
    for (int k = 1; k < 4; k++) s[k] = 8'($urandom_range(8'h80, 8'hBF));
    if (n == 2) begin
      s[0] = 8'($urandom_range(8'hC2, 8'hDF));
    end else if (n == 3) begin
      s[0] = 8'($urandom_range(8'hE0, 8'hEF));
      if (s[0] == 8'hE0) s[1] = 8'($urandom_range(8'hA0, 8'hBF));
      if (s[0] == 8'hED) s[1] = 8'($urandom_range(8'h80, 8'h9F));
    end else begin
      s[0] = 8'($urandom_range(8'hF0, 8'hF4));
      if (s[0] == 8'hF0) s[1] = 8'($urandom_range(8'h90, 8'hBF));
      if (s[0] == 8'hF4) s[1] = 8'($urandom_range(8'h80, 8'h8F));
    end
    return s;
  endfunction

  task automatic build_byte_stream();
    logic [3:0][7:0] s;
    int n;
    int roll;
    int cut;
    int target;
    // Extremes of ASCII, stray continuations, bad and good leads, range edges, truncation.
    add_byte(8'h00, 0); add_byte(8'h7F, 1);
    add_byte(8'h80, 0); add_byte(8'hBF, 0);
    add_byte(8'hC0, 0); add_byte(8'h80, 0);
    add_byte(8'hC2, 0); add_byte(8'h80, 0);
    add_byte(8'hDF, 0); add_byte(8'hBF, 1);
    add_byte(8'hE0, 0); add_byte(8'hA0, 0); add_byte(8'h80, 0);
    add_byte(8'hED, 0); add_byte(8'hA0, 0); add_byte(8'h80, 0);
    add_byte(8'hF4, 0); add_byte(8'h8F, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0);
    add_byte(8'hF0, 0); add_byte(8'h8F, 0); add_byte(8'hBF, 0); add_byte(8'hBF, 0);
    add_byte(8'hE2, 0); add_byte(8'h82, 1);
    add_byte(8'hF5, 1);

    target = byte_stream.size() + RandomBytes;
    while (byte_stream.size() < target) begin
      roll = $urandom_range(0, 99);
      n = $urandom_range(2, 4);
      s = legal_sequence(n);
      if (roll < 20) begin
        add_byte(8'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
      end else if (roll < 65) begin
        for (int k = 0; k < n; k++) add_byte(s[k], k == n - 1 && $urandom_range(0, 15) == 0);
      end else if (roll < 80) begin
        // One byte of an otherwise good sequence is replaced by anything.
        s[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
        for (int k = 0; k < n; k++) add_byte(s[k], 1'b0);
      end else if (roll < 90) begin
        cut = $urandom_range(1, n - 1);
        for (int k = 0; k < cut; k++) add_byte(s[k], k == cut - 1);
      end else begin
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  initial begin : cycle_watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    int stall_pct;
    int span;
    stall_pct = 0;
    span = 0;
    result_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    result_ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(50, 200);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      span--;
      if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : byte_source
    int gap_pct;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    gap_pct = 0;
    build_byte_stream();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (byte_stream[i]) begin
      if (i == byte_stream.size() * 17 / 20) quiet_tail = 1'b1;
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      item <= byte_stream[i];
      item_valid <= 1'b1;
      @(posedge clk);
      while (!item_ready) @(posedge clk);
      @(negedge clk);
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // Let a late or spurious result show up before the verdict.
    repeat (8) @(posedge clk);

    $display("Decoded %0d bytes under random request gaps and result stalls.", request_count);
    $display("Results checked: %0d code points, %0d illegal, %0d incomplete.",
             char_count, illegal_count, incomplete_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
